// ===== hw/rtl/mac_learning_table_aging_assert.svh =====
// Assertion macros for the MAC learning table.
// Used by the controller and the top level.
`ifndef MAC_LEARNING_TABLE_AGING_ASSERT_SVH
`define MAC_LEARNING_TABLE_AGING_ASSERT_SVH
`define MLT_ASSERT_IMPL(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("%m: label failed");
`define MLT_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("%m: label failed");
`endif

// ===== hw/rtl/mlta_pkg.sv =====
// Shared types and codes for the MAC learning table.
// No dependencies.
`default_nettype none
package mlta_pkg;
   localparam int MAC_BITS = 48;
   localparam int PORT_BITS = 4;
   localparam int AGE_BITS = 15;
   localparam int COUNT_BITS = 11;
   localparam int KIND_BITS = 2;
   localparam int STATUS_BITS = 2;
   localparam logic [KIND_BITS-1:0] KIND_LOOKUP = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_LEARN = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_TICK = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_NONE = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_INSERTED = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL = 2'd2;
   localparam logic [AGE_BITS-1:0] AGE_RESET = 15'd30;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 11'd2047;

   typedef struct packed {
      logic clear_step;
      logic rd_bucket;
      logic rd_sweep;
      logic do_access;
      logic do_sweep;
      logic tick_time;
      logic sweep_last;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic sweep_done;
   } sts_type;
endpackage
`default_nettype wire

// ===== hw/rtl/mlta_ram.sv =====
// Generic single-port write, single-port registered read RAM.
// No dependencies.
`default_nettype none
module mlta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ===== hw/rtl/mlta_ctrl.sv =====
// Controller state machine for the MAC learning table.
// Depends on mlta_pkg and the assertion macro header.
`default_nettype none
`include "mac_learning_table_aging_assert.svh"
module mlta_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [mlta_pkg::KIND_BITS-1:0] req_kind,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire mlta_pkg::sts_type              sts,
   output mlta_pkg::cmd_type                   cmd
);
   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_ACC   = 6'b000100,
      ST_SWRD  = 6'b001000,
      ST_SWEEP = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      take;

   assign rsp_valid = rsp_valid_ff;
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign take = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (take) begin
               if (req_kind == mlta_pkg::KIND_TICK) begin
                  cmd.tick_time = 1'b1;
                  cmd.rd_sweep = 1'b1;
                  state_in = ST_SWRD;
               end else begin
                  cmd.rd_bucket = 1'b1;
                  state_in = ST_ACC;
               end
            end
         end
         ST_ACC: begin
            cmd.do_access = 1'b1;
            cmd.load_out = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SWRD: begin
            cmd.rd_sweep = 1'b1;
            state_in = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.do_sweep = 1'b1;
            cmd.rd_sweep = 1'b1;
            if (sts.sweep_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.load_out = 1'b1;
            cmd.sweep_last = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MLT_ASSERT_IMPL(a_load_free, clock, reset, cmd.load_out, !(rsp_valid_ff && rsp_stall))
   `MLT_ASSERT_IMPL(a_no_take_busy, clock, reset, state_ff != ST_IDLE, !take)
   `MLT_ASSERT_NEXT(a_acc_resp, clock, reset, state_ff == ST_ACC, rsp_valid_ff)
endmodule
`default_nettype wire

// ===== hw/rtl/mlta_dp.sv =====
// Datapath of the MAC learning table: way RAMs, valid bits, timer, sweep.
// Depends on mlta_pkg and mlta_ram.
`default_nettype none
module mlta_dp #(
   parameter int WAYS = 4,
   parameter int TIME_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire mlta_pkg::cmd_type                 cmd,
   output mlta_pkg::sts_type                      sts,
   input  wire logic [mlta_pkg::KIND_BITS-1:0]    req_kind,
   input  wire logic [mlta_pkg::MAC_BITS-1:0]     req_mac_address,
   input  wire logic [mlta_pkg::PORT_BITS-1:0]    req_port_in,
   input  wire logic [mlta_pkg::AGE_BITS-1:0]     aging,
   output logic                                   rsp_hit,
   output logic      [mlta_pkg::PORT_BITS-1:0]    rsp_port_out,
   output logic      [mlta_pkg::STATUS_BITS-1:0]  rsp_status,
   output logic      [mlta_pkg::COUNT_BITS-1:0]   rsp_removed_count
);
   localparam int BUCKETS = 256;
   localparam int BBITS = 8;
   localparam int SLOTS = BUCKETS * WAYS;
   localparam int SBITS = $clog2(SLOTS);
   localparam int WBITS = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int DW = mlta_pkg::MAC_BITS + mlta_pkg::PORT_BITS + TIME_BITS;

   // valid bits live in a RAM of bucket-wide words, cleared after reset
   logic [BBITS-1:0]             clr_ff, clr_in;
   logic [BBITS-1:0]             sw_addr_ff, sw_addr_in, sw_q_ff, sw_q_in;
   logic                         sw_live_ff, sw_live_in;
   logic [mlta_pkg::KIND_BITS-1:0] kind_ff;
   logic [mlta_pkg::MAC_BITS-1:0]  mac_ff;
   logic [mlta_pkg::PORT_BITS-1:0] port_ff;
   logic [TIME_BITS-1:0]         now_ff, now_in;
   logic [mlta_pkg::COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                         hit_ff;
   logic [mlta_pkg::PORT_BITS-1:0] pout_ff;
   logic [mlta_pkg::STATUS_BITS-1:0] stat_ff;
   logic [mlta_pkg::COUNT_BITS-1:0] rem_ff;

   logic [BBITS-1:0] rd_b;
   logic [WAYS-1:0]  vrd, vwd;
   logic             vwe;
   logic [BBITS-1:0] vwa;
   logic [DW-1:0]    erd [WAYS];
   logic [WAYS-1:0]  ewe;
   logic [DW-1:0]    ewd;

   logic [WAYS-1:0]  match, freev, old;
   logic             any_hit, any_free;
   logic [WBITS-1:0] hit_w, free_w;
   logic [mlta_pkg::PORT_BITS-1:0] hit_port;
   logic [$clog2(WAYS+1)-1:0] nold;
   logic [mlta_pkg::COUNT_BITS:0] csum;

   assign rd_b = cmd.rd_bucket ? req_mac_address[BBITS-1:0] :
                 (cmd.rd_sweep ? sw_addr_ff : mac_ff[BBITS-1:0]);

   mlta_ram #(.WIDTH(WAYS), .DEPTH(BUCKETS)) u_valid (
      .clock(clock), .wr_en(vwe), .wr_addr(vwa), .wr_data(vwd),
      .rd_addr(rd_b), .rd_data(vrd));

   for (genvar g = 0; g < WAYS; g++) begin : g_way
      mlta_ram #(.WIDTH(DW), .DEPTH(BUCKETS)) u_ent (
         .clock(clock), .wr_en(ewe[g]), .wr_addr(mac_ff[BBITS-1:0]), .wr_data(ewd),
         .rd_addr(rd_b), .rd_data(erd[g]));
   end

   always_comb begin
      match = '0;
      freev = '0;
      old = '0;
      for (int w = 0; w < WAYS; w++) begin
         match[w] = vrd[w] && (erd[w][DW-1 -: mlta_pkg::MAC_BITS] == mac_ff);
         freev[w] = !vrd[w];
         old[w] = vrd[w] && ({{(32-TIME_BITS){1'b0}}, now_ff - erd[w][TIME_BITS-1:0]}
                  >= {17'd0, aging});
      end
      any_hit = |match;
      any_free = |freev;
      hit_w = '0;
      free_w = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_w = WBITS'(w);
         end
         if (freev[w]) begin
            free_w = WBITS'(w);
         end
      end
      hit_port = erd[hit_w][TIME_BITS +: mlta_pkg::PORT_BITS];
      nold = '0;
      for (int w = 0; w < WAYS; w++) begin
         nold = nold + {{($bits(nold)-1){1'b0}}, old[w]};
      end
      csum = {1'b0, cnt_ff} + (mlta_pkg::COUNT_BITS+1)'(nold);
   end

   always_comb begin
      vwe = 1'b0;
      vwa = mac_ff[BBITS-1:0];
      vwd = vrd;
      ewe = '0;
      ewd = {mac_ff, port_ff, now_ff};
      clr_in = clr_ff;
      sw_addr_in = sw_addr_ff;
      sw_q_in = sw_q_ff;
      sw_live_in = 1'b0;
      now_in = now_ff;
      cnt_in = cnt_ff;
      if (cmd.clear_step) begin
         vwe = 1'b1;
         vwa = clr_ff;
         vwd = '0;
         clr_in = clr_ff + 1'b1;
      end
      if (cmd.do_access && kind_ff == mlta_pkg::KIND_LEARN) begin
         if (any_hit) begin
            ewe[hit_w] = 1'b1;
            ewd = {erd[hit_w][DW-1 -: mlta_pkg::MAC_BITS], port_ff, now_ff};
         end else if (any_free) begin
            ewe[free_w] = 1'b1;
            vwe = 1'b1;
            vwd = vrd | (WAYS'(1) << free_w);
         end
      end
      if (cmd.tick_time) begin
         now_in = now_ff + 1'b1;
         cnt_in = '0;
         sw_addr_in = '0;
      end
      if (cmd.rd_sweep && !cmd.tick_time) begin
         sw_addr_in = sw_addr_ff + 1'b1;
         sw_q_in = sw_addr_ff;
         sw_live_in = 1'b1;
      end
      if (cmd.do_sweep && sw_live_ff) begin
         vwe = 1'b1;
         vwa = sw_q_ff;
         vwd = vrd & ~old;
         cnt_in = csum[mlta_pkg::COUNT_BITS] ? mlta_pkg::COUNT_MAX :
                  csum[mlta_pkg::COUNT_BITS-1:0];
      end
   end

   assign sts.clear_done = (clr_ff == BBITS'(BUCKETS - 1));
   assign sts.sweep_done = sw_live_ff && (sw_q_ff == BBITS'(BUCKETS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
         now_ff <= '0;
         sw_live_ff <= 1'b0;
      end else begin
         clr_ff <= clr_in;
         now_ff <= now_in;
         sw_live_ff <= sw_live_in;
      end
      sw_addr_ff <= sw_addr_in;
      sw_q_ff <= sw_q_in;
      cnt_ff <= cnt_in;
      if (cmd.rd_bucket || cmd.tick_time) begin
         kind_ff <= req_kind;
         mac_ff <= req_mac_address;
         port_ff <= req_port_in;
      end
      if (cmd.load_out) begin
         hit_ff <= 1'b0;
         pout_ff <= '0;
         stat_ff <= mlta_pkg::STATUS_NONE;
         rem_ff <= '0;
         if (cmd.sweep_last) begin
            rem_ff <= cnt_ff;
         end else if (kind_ff == mlta_pkg::KIND_LOOKUP || kind_ff == mlta_pkg::KIND_LEARN) begin
            if (any_hit) begin
               hit_ff <= 1'b1;
               pout_ff <= hit_port;
            end else if (kind_ff == mlta_pkg::KIND_LEARN) begin
               stat_ff <= any_free ? mlta_pkg::STATUS_INSERTED : mlta_pkg::STATUS_FULL;
            end
         end
      end
   end

   assign rsp_hit = hit_ff;
   assign rsp_port_out = pout_ff;
   assign rsp_status = stat_ff;
   assign rsp_removed_count = rem_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/mac_learning_table_aging.sv =====
// Top level of the MAC learning table with aging.
// Depends on mlta_pkg, mlta_ctrl, mlta_dp and the assertion macro header.
// Usage:
//   req_ channel carries kind, MAC and port; rsp_ returns hit, port, status and
//   removed count; csr_ writes the 15-bit aging threshold (reset 30).
//   An item transfers when valid is high and stall is low; one result per item.
//   Lookup and learn go from transfer to result through one registered
//   read of the bucket's way RAMs, then the compare and write-back.
//   A tick walks all 256 buckets one per cycle through the same RAM ports.
//   One item is in flight at a time; req_stall is high while busy or while a
//   stalled result still holds the output register.
//   After reset the valid-bit RAM is cleared one bucket a cycle, all 256
//   buckets, with req_stall high; csr writes are taken throughout.
//   A stalled result holds until the receiver drops rsp_stall.
//   Kind 3 returns an all-zero result and changes nothing.
`default_nettype none
`include "mac_learning_table_aging_assert.svh"
module mac_learning_table_aging #(
   parameter int WAYS = 4,
   parameter int TIME_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [mlta_pkg::KIND_BITS-1:0]        req_kind,
   input  wire logic [mlta_pkg::MAC_BITS-1:0]         req_mac_address,
   input  wire logic [mlta_pkg::PORT_BITS-1:0]        req_port_in,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic                                       rsp_hit,
   output logic      [mlta_pkg::PORT_BITS-1:0]        rsp_port_out,
   output logic      [mlta_pkg::STATUS_BITS-1:0]      rsp_status,
   output logic      [mlta_pkg::COUNT_BITS-1:0]       rsp_removed_count,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [mlta_pkg::AGE_BITS-1:0]         csr_data
);
   mlta_pkg::cmd_type cmd;
   mlta_pkg::sts_type sts;
   logic [mlta_pkg::AGE_BITS-1:0] aging_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         aging_ff <= mlta_pkg::AGE_RESET;
      end else if (csr_valid) begin
         aging_ff <= csr_data;
      end
   end

   mlta_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .sts(sts), .cmd(cmd));

   mlta_dp #(.WAYS(WAYS), .TIME_BITS(TIME_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts), .req_kind(req_kind),
      .req_mac_address(req_mac_address), .req_port_in(req_port_in), .aging(aging_ff),
      .rsp_hit(rsp_hit), .rsp_port_out(rsp_port_out), .rsp_status(rsp_status),
      .rsp_removed_count(rsp_removed_count));

   `MLT_ASSERT_IMPL(a_status_code, clock, reset, rsp_valid,
      rsp_status <= mlta_pkg::STATUS_FULL)
   `MLT_ASSERT_IMPL(a_tick_clean, clock, reset, rsp_valid && rsp_removed_count != '0,
      !rsp_hit && rsp_status == mlta_pkg::STATUS_NONE)
   `MLT_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_port_out))
endmodule
`default_nettype wire

// ===== verif/mlta_checker.sv =====
// Checker for the MAC learning table: watches the request, result and csr channels,
// keeps its own copy of the table and compares every result. Depends on mlta_pkg.
module mlta_checker
   import mlta_pkg::*;
#(
   parameter int WAYS = 4,
   parameter int TIME_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [KIND_BITS-1:0]   req_kind,
   input  logic [MAC_BITS-1:0]    req_mac_address,
   input  logic [PORT_BITS-1:0]   req_port_in,
   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic                   rsp_hit,
   input  logic [PORT_BITS-1:0]   rsp_port_out,
   input  logic [STATUS_BITS-1:0] rsp_status,
   input  logic [COUNT_BITS-1:0]  rsp_removed_count,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [AGE_BITS-1:0]    csr_data,
   output int                     error_count,
   output int                     pending_count
);
   localparam int SLOTS = 256 * WAYS;

   typedef struct packed {
      logic                   hit;
      logic [PORT_BITS-1:0]   port_out;
      logic [STATUS_BITS-1:0] status;
      logic [COUNT_BITS-1:0]  removed_count;
   } lookup_result_type;

   logic                 slot_used [SLOTS];
   logic [MAC_BITS-1:0]  slot_mac [SLOTS];
   logic [PORT_BITS-1:0] slot_port [SLOTS];
   logic [TIME_BITS-1:0] slot_stamp [SLOTS];
   logic [TIME_BITS-1:0] clock_secs;
   logic [AGE_BITS-1:0]  age_limit;
   lookup_result_type    expected_results [$];

   function automatic lookup_result_type table_access(logic [KIND_BITS-1:0] kind,
                                                      logic [MAC_BITS-1:0] mac,
                                                      logic [PORT_BITS-1:0] port);
      lookup_result_type r;
      int base;
      int found;
      int free_slot;
      int n;
      logic [TIME_BITS-1:0] age;
      r = '0;
      base = int'(mac[7:0]) * WAYS;
      found = -1;
      free_slot = -1;
      n = 0;
      if (kind == KIND_LOOKUP || kind == KIND_LEARN) begin
         for (int w = WAYS - 1; w >= 0; w--) begin
            if (slot_used[base + w] && slot_mac[base + w] == mac) found = base + w;
            if (!slot_used[base + w]) free_slot = base + w;
         end
         if (found >= 0) begin
            r.hit = 1'b1;
            r.port_out = slot_port[found];
            if (kind == KIND_LEARN) begin
               slot_port[found] = port;
               slot_stamp[found] = clock_secs;
            end
         end else if (kind == KIND_LEARN) begin
            if (free_slot >= 0) begin
               slot_used[free_slot] = 1'b1;
               slot_mac[free_slot] = mac;
               slot_port[free_slot] = port;
               slot_stamp[free_slot] = clock_secs;
               r.status = STATUS_INSERTED;
            end else begin
               r.status = STATUS_FULL;
            end
         end
      end else if (kind == KIND_TICK) begin
         clock_secs = clock_secs + 1'b1;
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_used[i]) begin
               age = clock_secs - slot_stamp[i];
               if (age >= age_limit) begin
                  slot_used[i] = 1'b0;
                  n++;
               end
            end
         end
         r.removed_count = (n > int'(COUNT_MAX)) ? COUNT_MAX : n[COUNT_BITS-1:0];
      end
      return r;
   endfunction

   assign pending_count = expected_results.size();

   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) slot_used[i] = 1'b0;
         clock_secs = '0;
         age_limit = AGE_RESET;
         expected_results.delete();
         error_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result hit=%0d port=%0d status=%0d removed=%0d",
                        $time, rsp_hit, rsp_port_out, rsp_status, rsp_removed_count);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_hit !== want.hit) begin
                  $display("%0t: hit expected %0d actual %0d", $time, want.hit, rsp_hit);
                  error_count++;
               end
               if (rsp_port_out !== want.port_out) begin
                  $display("%0t: port_out expected %0d actual %0d",
                           $time, want.port_out, rsp_port_out);
                  error_count++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, want.status, rsp_status);
                  error_count++;
               end
               if (rsp_removed_count !== want.removed_count) begin
                  $display("%0t: removed_count expected %0d actual %0d",
                           $time, want.removed_count, rsp_removed_count);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(table_access(req_kind, req_mac_address, req_port_in));
         if (csr_valid && csr_ready) age_limit = csr_data;
      end
   end
endmodule

// ===== verif/tb_mac_learning_table_aging.sv =====
// Testbench top for the MAC learning table: drives requests, aging writes and
// result stalls, and gives the verdict. Depends on mlta_pkg, mlta_checker and the block.
module tb_mac_learning_table_aging;
   import mlta_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int LONG_HOLD = 400;
   localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [KIND_BITS-1:0]   req_kind = KIND_LOOKUP;
   logic [MAC_BITS-1:0]    req_mac_address = '0;
   logic [PORT_BITS-1:0]   req_port_in = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic                   rsp_hit;
   logic [PORT_BITS-1:0]   rsp_port_out;
   logic [STATUS_BITS-1:0] rsp_status;
   logic [COUNT_BITS-1:0]  rsp_removed_count;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [AGE_BITS-1:0]    csr_data = '0;
   int                     error_count;
   int                     pending_count;
   int                     cycle_count = 0;
   bit                     gaps_on = 1'b1;
   bit                     hold_request = 1'b0;
   logic                   long_hold = 1'b0;
   logic [39:0]            mac_upper [8];
   logic [7:0]             hot_buckets [4] = '{8'h00, 8'h5a, 8'hff, 8'h13};

   always #2 clock = ~clock;

   mac_learning_table_aging u_dut (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_mac_address, .req_port_in,
      .rsp_valid, .rsp_stall, .rsp_hit, .rsp_port_out, .rsp_status, .rsp_removed_count,
      .csr_valid, .csr_ready, .csr_data
   );

   mlta_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_kind, .req_mac_address, .req_port_in,
      .rsp_valid, .rsp_stall, .rsp_hit, .rsp_port_out, .rsp_status, .rsp_removed_count,
      .csr_valid, .csr_ready, .csr_data, .error_count, .pending_count
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      wait (hold_request);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin
      int burst;
      burst = 0;
      forever begin
         @(posedge clock);
         if (burst == 0 && gaps_on && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 4);
         rsp_stall <= long_hold || burst > 0;
         if (burst > 0) burst--;
      end
   end

   task automatic send(logic [KIND_BITS-1:0] kind, logic [MAC_BITS-1:0] mac,
                       logic [PORT_BITS-1:0] port);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_mac_address <= mac;
      req_port_in <= port;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_aging(logic [AGE_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random();
      logic [MAC_BITS-1:0] mac;
      logic [KIND_BITS-1:0] kind;
      int pick;
      if ($urandom_range(0, 9) < 7)
         mac = {mac_upper[$urandom_range(0, 7)], hot_buckets[$urandom_range(0, 3)]};
      else
         mac = MAC_BITS'({$urandom, $urandom});
      pick = $urandom_range(0, 99);
      if (pick < 40) kind = KIND_LOOKUP;
      else if (pick < 86) kind = KIND_LEARN;
      else if (pick < 97) kind = KIND_TICK;
      else kind = KIND_UNUSED;
      send(kind, mac, PORT_BITS'($urandom));
   endtask

   initial begin
      logic [AGE_BITS-1:0] ages [6];
      ages = '{15'd2, 15'd1, 15'd4, 15'h7fff, 15'd3, 15'd0};
      for (int i = 0; i < 8; i++) mac_upper[i] = 40'({$urandom, $urandom});
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send(KIND_LEARN, '1, 4'hf);
      send(KIND_LEARN, '0, 4'h0);
      send(KIND_LOOKUP, '1, 4'h3);
      send(KIND_LOOKUP, '0, 4'h3);
      send(KIND_LEARN, '1, 4'h5);
      send(KIND_LOOKUP, '1, 4'h0);
      for (int i = 1; i <= 4; i++) send(KIND_LEARN, {40'(i), 8'h00}, PORT_BITS'(i));
      send(KIND_LEARN, {40'hffff_0000_aa, 8'h00}, 4'h9);
      send(KIND_LOOKUP, {40'h1234_5678_9a, 8'h00}, 4'h0);
      send(KIND_UNUSED, '1, 4'hf);
      send(KIND_TICK, 48'h0, 4'h0);
      send(KIND_LOOKUP, '0, 4'h0);
      drain();
      write_aging(15'd0);
      send(KIND_TICK, '1, 4'hf);
      send(KIND_LOOKUP, '1, 4'h0);
      send(KIND_TICK, '0, 4'h0);

      for (int p = 0; p < 6; p++) begin
         drain();
         write_aging(ages[p]);
         if (p == 1) hold_request = 1'b1;
         if (p == 5) gaps_on = 1'b0;
         repeat (108) send_random();
      end
      drain();
      if (error_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule

// ===== mac_learning_table_aging.f =====
+incdir+hw/rtl
hw/rtl/mlta_pkg.sv
hw/rtl/mlta_ram.sv
hw/rtl/mlta_ctrl.sv
hw/rtl/mlta_dp.sv
hw/rtl/mac_learning_table_aging.sv
verif/mlta_checker.sv
verif/tb_mac_learning_table_aging.sv
